// ===== rtl/gde_pkg.sv =====
`default_nettype none
package gde_pkg;

  localparam int GB        = 56;
  localparam int DIV_STEPS = 63;
  localparam int SQ_STEPS  = 56;
  localparam int NTERMS    = 39;

  localparam logic [63:0] ONE_G    = 64'h0100_0000_0000_0000;
  localparam logic [63:0] LN2_G    = 64'h00B1_7217_F7D1_CF7A;
  localparam logic [63:0] LOG2E_G  = 64'h0171_5476_52B8_2FE1;
  localparam logic [63:0] EXP_LIM  = 64'h5000_0000_0000_0000;  // 80.0
  localparam logic [63:0] T_CAP    = 64'h4000_0000_0000_0000;  // 64.0
  localparam logic [63:0] T_LARGE  = 64'h0480_0000_0000_0000;  // 4.5
  localparam logic [63:0] PROD_LIM = 64'h4000_0000_0000_0000;  // 2^62

  localparam logic [1:0] OP_DENSITY = 2'd0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SCALE = 3'd1,
    ST_P_RANGE   = 3'd2,
    ST_NEG_INF   = 3'd3,
    ST_POS_INF   = 3'd4,
    ST_SAT       = 3'd5
  } status_e;

  // per-item record carried alongside the arithmetic units
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] x;
    logic [63:0] mu;
    logic [63:0] sg;
    logic        cap;
    logic        neg;
    logic [63:0] t;
    logic [63:0] l1;
    logic [63:0] g;
    logic [63:0] arg2;
    logic [63:0] prod;
    logic        povf;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/gde_mul.sv =====
`default_nettype none
module gde_mul import gde_pkg::*; #(
  parameter int TAG_W      = 1,
  parameter bit SIGNED_MUL = 1'b0,
  parameter bit ROUND      = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [63:0]      p_o,
  output logic             ovf_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [63:0]      ua, ub;
  logic             neg_d;
  logic             v1_q, v2_q;
  logic [63:0]      p00_q, p01_q, p10_q, p11_q;
  logic             neg_q;
  logic [TAG_W-1:0] tag1_q, tag2_q;
  logic [63:0]      p_d, p_q;
  logic             ovf_d, ovf_q;

  always_comb begin
    ua    = (SIGNED_MUL && a_i[63]) ? (64'd0 - a_i) : a_i;
    ub    = (SIGNED_MUL && b_i[63]) ? (64'd0 - b_i) : b_i;
    neg_d = SIGNED_MUL && (a_i[63] ^ b_i[63]);
  end

  always_comb begin
    logic [127:0] full;
    logic [63:0]  r;
    logic         ovf_u;
    full = {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
         + {p11_q, 64'd0};
    if (ROUND) full = full + {64'd0, ONE_G >> 1};
    ovf_u = |full[127:120];
    r     = ovf_u ? '1 : full[119:56];
    if (SIGNED_MUL) begin
      ovf_d = ovf_u | r[63];
      if (r[63]) r = 64'h7FFF_FFFF_FFFF_FFFF;
      p_d = neg_q ? (64'd0 - r) : r;
    end else begin
      ovf_d = ovf_u;
      p_d   = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p00_q  <= {32'd0, ua[31:0]}  * {32'd0, ub[31:0]};
    p01_q  <= {32'd0, ua[31:0]}  * {32'd0, ub[63:32]};
    p10_q  <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
    p11_q  <= {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
    neg_q  <= neg_d;
    tag1_q <= tag_i;
    p_q    <= p_d;
    ovf_q  <= ovf_d;
    tag2_q <= tag1_q;
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign ovf_o   = ovf_q;
  assign tag_o   = tag2_q;

endmodule
`default_nettype wire

// ===== rtl/gde_div.sv =====
`default_nettype none
module gde_div import gde_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [63:0]          rem_i,
  input  logic [6:0]           num_i,
  input  logic [63:0]          den_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [DIV_STEPS-1:0] q_o,
  output logic [TAG_W-1:0]     tag_o
);

  logic [63:0]          rem_q [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS+1];
  logic [6:0]           num_q [DIV_STEPS+1];
  logic [63:0]          den_q [DIV_STEPS+1];
  logic [TAG_W-1:0]     tag_q [DIV_STEPS+1];
  logic                 vld_q [DIV_STEPS+1];

  assign rem_q[0] = rem_i;
  assign quo_q[0] = '0;
  assign num_q[0] = num_i;
  assign den_q[0] = den_i;
  assign tag_q[0] = tag_i;
  assign vld_q[0] = valid_i;

  // one restoring quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [63:0] rem2, rem_d;
    logic        ge;

    always_comb begin
      rem2  = {rem_q[j][62:0], num_q[j][6]};
      ge    = rem2 >= den_q[j];
      rem_d = ge ? (rem2 - den_q[j]) : rem2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[j+1] <= 1'b0;
      else vld_q[j+1] <= vld_q[j];
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= rem_d;
      quo_q[j+1] <= {quo_q[j][DIV_STEPS-2:0], ge};
      num_q[j+1] <= {num_q[j][5:0], 1'b0};
      den_q[j+1] <= den_q[j];
      tag_q[j+1] <= tag_q[j];
    end
  end

  assign valid_o = vld_q[DIV_STEPS];
  assign q_o     = quo_q[DIV_STEPS];
  assign tag_o   = tag_q[DIV_STEPS];

endmodule
`default_nettype wire

// ===== rtl/gde_log.sv =====
`default_nettype none
module gde_log import gde_pkg::*; #(
  parameter int TAG_W = 1,
  parameter int FB    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      v_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [63:0]      ln_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int SQ_TAG_W = SQ_STEPS + 6 + TAG_W;

  // leading-one search: byte group, then bit in byte, then normalize
  logic [2:0]       gi_d, gi_q, bi_d;
  logic [7:0]       byte_q;
  logic [63:0]      v1_q, v2_q, m_d, m3_q;
  logic [5:0]       n2_q, n3_q;
  logic [TAG_W-1:0] tag1_q, tag2_q, tag3_q;
  logic             vl1_q, vl2_q, vl3_q;

  always_comb begin
    gi_d = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (|v_i[g*8 +: 8]) gi_d = 3'(g);
    end
  end

  always_comb begin
    bi_d = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_q[b]) bi_d = 3'(b);
    end
  end

  always_comb begin
    if (n2_q <= 6'd56) m_d = v2_q << (6'd56 - n2_q);
    else m_d = v2_q >> (n2_q - 6'd56);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl1_q <= 1'b0;
      vl2_q <= 1'b0;
      vl3_q <= 1'b0;
    end else begin
      vl1_q <= valid_i;
      vl2_q <= vl1_q;
      vl3_q <= vl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gi_q   <= gi_d;
    byte_q <= v_i[{gi_d, 3'b000} +: 8];
    v1_q   <= v_i;
    tag1_q <= tag_i;
    n2_q   <= {gi_q, bi_d};
    v2_q   <= v1_q;
    tag2_q <= tag1_q;
    m3_q   <= m_d;
    n3_q   <= n2_q;
    tag3_q <= tag2_q;
  end

  // repeated squaring, one fraction bit per step
  logic [63:0]         m_a  [SQ_STEPS+1];
  logic [SQ_STEPS-1:0] fr_a [SQ_STEPS+1];
  logic [5:0]          n_a  [SQ_STEPS+1];
  logic [TAG_W-1:0]    tg_a [SQ_STEPS+1];
  logic                vl_a [SQ_STEPS+1];

  assign m_a[0]  = m3_q;
  assign fr_a[0] = '0;
  assign n_a[0]  = n3_q;
  assign tg_a[0] = tag3_q;
  assign vl_a[0] = vl3_q;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [63:0]         p;
    logic [SQ_STEPS-1:0] fr;
    logic                hi;

    gde_mul #(.TAG_W(SQ_TAG_W), .SIGNED_MUL(1'b0), .ROUND(1'b0)) u_sq (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vl_a[j]),
      .a_i     (m_a[j]),
      .b_i     (m_a[j]),
      .tag_i   ({fr_a[j], n_a[j], tg_a[j]}),
      .valid_o (vl_a[j+1]),
      .p_o     (p),
      .ovf_o   (),
      .tag_o   ({fr, n_a[j+1], tg_a[j+1]})
    );

    assign hi        = p[57];
    assign m_a[j+1]  = hi ? {1'b0, p[63:1]} : p;
    assign fr_a[j+1] = fr | (hi ? (SQ_STEPS'(1) << (SQ_STEPS-1-j)) : '0);
  end

  logic [7:0]  ipart;
  logic [63:0] log2_val;

  assign ipart    = {2'b00, n_a[SQ_STEPS]} - 8'(FB);
  assign log2_val = {ipart, fr_a[SQ_STEPS]};

  gde_mul #(.TAG_W(TAG_W), .SIGNED_MUL(1'b1), .ROUND(1'b1)) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vl_a[SQ_STEPS]),
    .a_i     (log2_val),
    .b_i     (LN2_G),
    .tag_i   (tg_a[SQ_STEPS]),
    .valid_o (valid_o),
    .p_o     (ln_o),
    .ovf_o   (),
    .tag_o   (tag_o)
  );

endmodule
`default_nettype wire

// ===== rtl/gde_exp.sv =====
`default_nettype none
module gde_exp import gde_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [63:0]      u_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [63:0]      m_o,
  output logic [7:0]       k_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int TT_W = 64 + 64 + 8 + TAG_W;

  logic [63:0]      uc, y;
  logic [TAG_W-1:0] tag_y, tag_r_q;
  logic             vld_y, vld_r_q;
  logic [7:0]       k_r_q;
  logic [63:0]      r_q;

  always_comb begin
    if ($signed(u_i) > $signed(EXP_LIM)) uc = EXP_LIM;
    else if ($signed(u_i) < -$signed(EXP_LIM)) uc = 64'd0 - EXP_LIM;
    else uc = u_i;
  end

  gde_mul #(.TAG_W(TAG_W), .SIGNED_MUL(1'b1), .ROUND(1'b1)) u_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .a_i     (uc),
    .b_i     (LOG2E_G),
    .tag_i   (tag_i),
    .valid_o (vld_y),
    .p_o     (y),
    .ovf_o   (),
    .tag_o   (tag_y)
  );

  // integer part is floor(y), the fraction goes through the series
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_r_q <= 1'b0;
    else vld_r_q <= vld_y;
  end

  always_ff @(posedge clk_i) begin
    k_r_q   <= y[63:56];
    r_q     <= {8'd0, y[55:0]};
    tag_r_q <= tag_y;
  end

  logic [63:0]      term_q [NTERMS+1];
  logic [63:0]      sum_q  [NTERMS+1];
  logic [63:0]      z_q    [NTERMS+1];
  logic [7:0]       k_q    [NTERMS+1];
  logic [TAG_W-1:0] tg_q   [NTERMS+1];
  logic             vld_q  [NTERMS+1];

  gde_mul #(.TAG_W(8 + TAG_W), .SIGNED_MUL(1'b0), .ROUND(1'b1)) u_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_r_q),
    .a_i     (r_q),
    .b_i     (LN2_G),
    .tag_i   ({k_r_q, tag_r_q}),
    .valid_o (vld_q[0]),
    .p_o     (z_q[0]),
    .ovf_o   (),
    .tag_o   ({k_q[0], tg_q[0]})
  );

  assign term_q[0] = ONE_G;
  assign sum_q[0]  = ONE_G;

  // Taylor terms; once a term is zero all later ones stay zero
  for (genvar j = 0; j < NTERMS; j++) begin : g_term
    // p / n as (p * ceil(2^62 / n)) >> 62, exact for p < 2^56 and n < 64
    localparam logic [63:0] RecipN = ((64'd1 << 62) + 64'(j)) / 64'(j + 1);
    logic [63:0]      p, q, sum_m, z_m, sum_n, z_n, term_d;
    logic [7:0]       k_m, k_n;
    logic [TAG_W-1:0] tg_m, tg_n;
    logic             vld_m, vld_n;

    gde_mul #(.TAG_W(TT_W), .SIGNED_MUL(1'b0), .ROUND(1'b0)) u_t (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_q[j]),
      .a_i     (term_q[j]),
      .b_i     (z_q[j]),
      .tag_i   ({sum_q[j], z_q[j], k_q[j], tg_q[j]}),
      .valid_o (vld_m),
      .p_o     (p),
      .ovf_o   (),
      .tag_o   ({sum_m, z_m, k_m, tg_m})
    );

    gde_mul #(.TAG_W(TT_W), .SIGNED_MUL(1'b0), .ROUND(1'b0)) u_d (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_m),
      .a_i     (p),
      .b_i     (RecipN),
      .tag_i   ({sum_m, z_m, k_m, tg_m}),
      .valid_o (vld_n),
      .p_o     (q),
      .ovf_o   (),
      .tag_o   ({sum_n, z_n, k_n, tg_n})
    );

    assign term_d = {6'd0, q[63:6]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[j+1] <= 1'b0;
      else vld_q[j+1] <= vld_n;
    end

    always_ff @(posedge clk_i) begin
      term_q[j+1] <= term_d;
      sum_q[j+1]  <= sum_n + term_d;
      z_q[j+1]    <= z_n;
      k_q[j+1]    <= k_n;
      tg_q[j+1]   <= tg_n;
    end
  end

  assign valid_o = vld_q[NTERMS];
  assign m_o     = sum_q[NTERMS];
  assign k_o     = k_q[NTERMS];
  assign tag_o   = tg_q[NTERMS];

endmodule
`default_nettype wire

// ===== rtl/gumbel_distribution_evaluator.sv =====
`default_nettype none
// Gumbel distribution evaluator: density, cumulative or quantile per item.
// Input channel: an item (op_i, operand_i) is taken at a rising edge with
// start high and busy low. busy stays low, so one item can enter every cycle.
// Output channel: each result is on value_out_o / status_o for exactly one
// cycle, flagged by done_o; the receiver must take it then, it cannot stall.
// Config channel: cfg_valid_i with cfg_ready_o (always high) writes register
// cfg_index_i (0 location, 1 scale) with cfg_data_i. Write only while idle;
// each item samples location and scale as it enters.
// Every op takes the same path from start to done_o. Throughput is one item
// per cycle. The path is the chain: 63-stage divider, then logarithm
// (56 squarings) and exponential (39 series terms), each run twice, plus
// input, middle, product and output stages.
// Reset clears every valid bit in flight and sets location 0, scale 1.0.
module gumbel_distribution_evaluator import gde_pkg::*; #(
  parameter int FRAC_BITS = 32,
  parameter int INT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] operand_i,
  output logic                          done_o,
  output logic [INT_BITS+FRAC_BITS-1:0] value_out_o,
  output logic [2:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [INT_BITS+FRAC_BITS-1:0] cfg_data_i
);

  localparam int QW = INT_BITS + FRAC_BITS;
  localparam logic [63:0] VAL_MAX = (64'd1 << (QW - 1)) - 64'd1;
  localparam logic [63:0] VAL_MIN = ~VAL_MAX;
  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_LSB = 64'd1 << (GB - FRAC_BITS - 1);
  localparam int ITEM_W = $bits(item_t);

  function automatic logic [63:0] scale_g(logic [63:0] m, logic [7:0] k);
    logic [8:0]  s;
    logic [63:0] res;
    s = 9'd0;
    if (!k[7]) begin
      res = (k < 8'd64) ? (m << k[5:0]) : 64'd0;
    end else begin
      s = 9'd0 - {k[7], k};
      if (s > 9'd58) res = 64'd0;
      else res = (m + (64'd1 << (s[5:0] - 6'd1))) >> s[5:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [QW-1:0] loc_q, scale_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q   <= '0;
      scale_q <= QW'(ONE_Q);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i) scale_q <= cfg_data_i;
      else loc_q <= cfg_data_i;
    end
  end

  // input stage
  item_t s0_d, s0_q;
  logic  s0_vld_q;

  always_comb begin
    s0_d    = '0;
    s0_d.op = op_i;
    s0_d.x  = {{(64-QW){operand_i[QW-1]}}, operand_i};
    s0_d.mu = {{(64-QW){loc_q[QW-1]}}, loc_q};
    s0_d.sg = {{(64-QW){scale_q[QW-1]}}, scale_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else s0_vld_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
  end

  // t = (x - mu) / sigma; quotient above 64.0 is capped up front
  item_t       dv_in;
  logic [63:0] dd, ad;

  always_comb begin
    dd        = s0_q.x - s0_q.mu;
    ad        = dd[63] ? (64'd0 - dd) : dd;
    dv_in     = s0_q;
    dv_in.neg = dd[63];
    dv_in.cap = {6'd0, ad} > {s0_q.sg, 6'd0};
  end

  logic [DIV_STEPS-1:0] quo;
  logic [ITEM_W-1:0]    dv_tag;
  logic                 dv_vld;

  gde_div #(.TAG_W(ITEM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .rem_i   ({7'd0, ad[63:7]}),
    .num_i   (ad[6:0]),
    .den_i   (s0_q.sg),
    .tag_i   (dv_in),
    .valid_o (dv_vld),
    .q_o     (quo),
    .tag_o   (dv_tag)
  );

  item_t       l1_in;
  logic [63:0] tm, v1;

  always_comb begin
    l1_in   = item_t'(dv_tag);
    tm      = l1_in.cap ? T_CAP : {1'b0, quo};
    l1_in.t = l1_in.neg ? (64'd0 - tm) : tm;
    v1      = (l1_in.op == OP_DENSITY) ? l1_in.sg : (ONE_Q - l1_in.x);
  end

  // ln(sigma) for the density, ln(1 - p) for the quantile
  logic [63:0]       ln1;
  logic [ITEM_W-1:0] l1_tag;
  logic              l1_vld;

  gde_log #(.TAG_W(ITEM_W), .FB(FRAC_BITS)) u_log1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_vld),
    .v_i     (v1),
    .tag_i   (l1_in),
    .valid_o (l1_vld),
    .ln_o    (ln1),
    .tag_o   (l1_tag)
  );

  item_t e1_in;

  always_comb begin
    e1_in    = item_t'(l1_tag);
    e1_in.l1 = ln1;
  end

  logic [63:0]       em1;
  logic [7:0]        ek1;
  logic [ITEM_W-1:0] e1_tag;
  logic              e1_vld;

  gde_exp #(.TAG_W(ITEM_W)) u_exp1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l1_vld),
    .u_i     (e1_in.t),
    .tag_i   (e1_in),
    .valid_o (e1_vld),
    .m_o     (em1),
    .k_o     (ek1),
    .tag_o   (e1_tag)
  );

  // middle stage: arguments of the second exp / log
  item_t mid_d, mid_q;
  logic  mid_vld_q;

  always_comb begin
    logic [63:0] e;
    logic [63:0] gg;
    mid_d = item_t'(e1_tag);
    e     = scale_g(em1, ek1);
    if (mid_d.op == OP_DENSITY) mid_d.arg2 = mid_d.t - e - mid_d.l1;
    else mid_d.arg2 = 64'd0 - e;
    gg = 64'd0 - mid_d.l1;
    mid_d.g = ($signed(gg) <= 0) ? 64'd1 : gg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mid_vld_q <= 1'b0;
    else mid_vld_q <= e1_vld;
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  logic [63:0]       ln2v;
  logic [ITEM_W-1:0] l2_tag;
  logic              l2_vld;

  gde_log #(.TAG_W(ITEM_W), .FB(GB)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_vld_q),
    .v_i     (mid_q.g),
    .tag_i   (mid_q),
    .valid_o (l2_vld),
    .ln_o    (ln2v),
    .tag_o   (l2_tag)
  );

  item_t             l2_item, pr_item, e2_in;
  logic [63:0]       prod;
  logic              prod_ovf;
  logic [ITEM_W-1:0] pr_tag;
  logic              pr_vld;

  assign l2_item = item_t'(l2_tag);

  gde_mul #(.TAG_W(ITEM_W), .SIGNED_MUL(1'b1), .ROUND(1'b1)) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l2_vld),
    .a_i     (l2_item.sg),
    .b_i     (ln2v),
    .tag_i   (l2_tag),
    .valid_o (pr_vld),
    .p_o     (prod),
    .ovf_o   (prod_ovf),
    .tag_o   (pr_tag)
  );

  always_comb begin
    pr_item      = item_t'(pr_tag);
    e2_in        = pr_item;
    e2_in.prod   = prod;
    e2_in.povf   = prod_ovf;
  end

  logic [63:0]       em2;
  logic [7:0]        ek2;
  logic [ITEM_W-1:0] e2_tag;
  logic              e2_vld;

  gde_exp #(.TAG_W(ITEM_W)) u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pr_vld),
    .u_i     (e2_in.arg2),
    .tag_i   (e2_in),
    .valid_o (e2_vld),
    .m_o     (em2),
    .k_o     (ek2),
    .tag_o   (e2_tag)
  );

  // output stage: special cases, saturation and format conversion
  item_t       fi;
  logic [63:0] val_d;
  status_e     st_d;

  always_comb begin
    logic [9:0]  sh;
    logic [9:0]  s;
    logic [63:0] p, v, w, r;
    logic        o;
    fi    = item_t'(e2_tag);
    val_d = 64'd0;
    st_d  = ST_OK;
    sh    = {{2{ek2[7]}}, ek2} + 10'(FRAC_BITS - GB);
    s     = 10'd0 - sh;
    p     = fi.prod;
    v     = 64'd0;
    w     = 64'd0;
    r     = 64'd0;
    o     = fi.povf;
    if ($signed(fi.sg) <= 0) begin
      st_d = ST_BAD_SCALE;
    end else if (fi.op[1]) begin
      if ($signed(fi.x) < 0 || $signed(fi.x) > $signed(ONE_Q)) begin
        st_d = ST_P_RANGE;
      end else if (fi.x == 64'd0) begin
        st_d  = ST_NEG_INF;
        val_d = VAL_MIN;
      end else if (fi.x == ONE_Q) begin
        st_d  = ST_POS_INF;
        val_d = VAL_MAX;
      end else begin
        if ($signed(p) > $signed(PROD_LIM)) begin
          p = PROD_LIM;
          o = 1'b1;
        end else if ($signed(p) < -$signed(PROD_LIM)) begin
          p = 64'd0 - PROD_LIM;
          o = 1'b1;
        end
        v = fi.mu + p;
        if ($signed(v) > $signed(VAL_MAX)) begin
          v = VAL_MAX;
          o = 1'b1;
        end else if ($signed(v) < $signed(VAL_MIN)) begin
          v = VAL_MIN;
          o = 1'b1;
        end
        val_d = v;
        st_d  = o ? ST_SAT : ST_OK;
      end
    end else if ($signed(fi.t) >= $signed(T_LARGE)) begin
      val_d = (fi.op == OP_DENSITY) ? 64'd0 : ONE_Q;
    end else if (fi.op == OP_DENSITY) begin
      if (!sh[9]) begin
        if (sh >= 10'd62 || em2 > (VAL_MAX >> sh[5:0])) begin
          val_d = VAL_MAX;
          st_d  = ST_SAT;
        end else begin
          val_d = em2 << sh[5:0];
        end
      end else if (s <= 10'd58) begin
        r = (em2 + (64'd1 << (s[5:0] - 6'd1))) >> s[5:0];
        if (r > VAL_MAX) begin
          val_d = VAL_MAX;
          st_d  = ST_SAT;
        end else begin
          val_d = r;
        end
      end
    end else begin
      w = scale_g(em2, ek2);
      if (w > ONE_G) w = ONE_G;
      val_d = ((ONE_G - w) + HALF_LSB) >> (GB - FRAC_BITS);
    end
  end

  logic          done_q;
  logic [QW-1:0] value_q;
  status_e       status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= e2_vld;
  end

  always_ff @(posedge clk_i) begin
    value_q  <= val_d[QW-1:0];
    status_q <= st_d;
  end

  assign done_o      = done_q;
  assign value_out_o = value_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire
